// ===== rtl/rthsv_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and divider step for the RGB to HSV pipeline.
package rthsv_pkg;

  localparam int FRAC_BITS = 6;
  localparam int CH_W      = 8;
  localparam int HUE_W     = 15;
  localparam int SAT_W     = 14;
  localparam int VAL_W     = 8;

  // hue quotient stays below 512 degrees, saturation below 256
  localparam int QW         = CH_W + 1 + FRAC_BITS;
  localparam int NUM_W      = 2 * CH_W + 1 + FRAC_BITS;
  localparam int SUM_W      = CH_W + 3;
  localparam int STEPS      = 4;
  localparam int DIV_STAGES = (QW + STEPS - 1) / STEPS;

  localparam int DEG_SECTOR = 60;
  localparam int FULL_SCALE = 255;
  localparam int DEG_TURN   = 360;

  localparam logic [QW-1:0] HUE_TURN = QW'(DEG_TURN) << FRAC_BITS;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    sector_e         sector;
  } front_t;

  // one restoring division in flight: divisor, partial remainder,
  // and the low numerator bits that turn into quotient bits
  typedef struct packed {
    logic [CH_W-1:0] den;
    logic [CH_W-1:0] rem;
    logic [QW-1:0]   work;
  } div_t;

  typedef struct packed {
    div_t             hue;
    div_t             sat;
    logic             neg;
    logic [VAL_W-1:0] val;
  } div_beat_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] value;
  } hsv_t;

  function automatic div_t div_step(input div_t d);
    div_t        o;
    logic [CH_W:0] t;
    o = d;
    t = {d.rem, d.work[QW-1]};
    if (t >= {1'b0, d.den}) begin
      o.rem  = CH_W'(t - {1'b0, d.den});
      o.work = {d.work[QW-2:0], 1'b1};
    end else begin
      o.rem  = t[CH_W-1:0];
      o.work = {d.work[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/rthsv_if.sv =====
`timescale 1ns / 1ps
// Pixel and HSV stream interfaces with valid/ready handshake.
interface rthsv_rgb_if;
  import rthsv_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_hsv_if;
  import rthsv_pkg::*;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

// ===== rtl/rthsv_front.sv =====
`timescale 1ns / 1ps
// Front end: max/min and sector pick, then numerators and divisors.
module rthsv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rthsv_pkg::div_beat_t  out_data_o
);
  import rthsv_pkg::*;

  logic            s1_valid_q;
  logic            s1_ready;
  front_t          s1_d, s1_q;
  logic [CH_W-1:0] mx, mn;

  logic            s2_valid_q;
  logic            s2_ready;
  div_beat_t       s2_d, s2_q;
  logic [SUM_W-1:0] term;
  logic [NUM_W-1:0] hnum, snum;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = s1_ready;

  // stage 1: extremes and sector, red wins ties over green over blue
  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    s1_d.red   = red_i;
    s1_d.green = green_i;
    s1_d.blue  = blue_i;
    s1_d.mx    = mx;
    s1_d.delta = mx - mn;
    if (red_i == mx)        s1_d.sector = SEC_RED;
    else if (green_i == mx) s1_d.sector = SEC_GREEN;
    else                    s1_d.sector = SEC_BLUE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: sector term is never negative except in the red sector
  always_comb begin
    s2_d.neg = 1'b0;
    case (s1_q.sector)
      SEC_RED: begin
        if (s1_q.green >= s1_q.blue) begin
          term = SUM_W'(s1_q.green - s1_q.blue);
        end else begin
          term     = SUM_W'(s1_q.blue - s1_q.green);
          s2_d.neg = 1'b1;
        end
      end
      SEC_GREEN: term = (SUM_W'(s1_q.delta) << 1) + SUM_W'(s1_q.blue) - SUM_W'(s1_q.red);
      SEC_BLUE:  term = (SUM_W'(s1_q.delta) << 2) + SUM_W'(s1_q.red) - SUM_W'(s1_q.green);
      default:   term = '0;
    endcase
    hnum = (NUM_W'(term) * NUM_W'(DEG_SECTOR)) << FRAC_BITS;
    snum = (NUM_W'(s1_q.delta) * NUM_W'(FULL_SCALE)) << FRAC_BITS;

    s2_d.hue.den  = (s1_q.delta == '0) ? CH_W'(1) : s1_q.delta;
    s2_d.hue.rem  = hnum[NUM_W-1:QW];
    s2_d.hue.work = hnum[QW-1:0];
    s2_d.sat.den  = (s1_q.mx == '0) ? CH_W'(1) : s1_q.mx;
    s2_d.sat.rem  = snum[NUM_W-1:QW];
    s2_d.sat.work = snum[QW-1:0];
    s2_d.val      = s1_q.mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

// ===== rtl/rthsv_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: hue and saturation quotients, STEPS bits per stage.
module rthsv_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rthsv_pkg::div_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rthsv_pkg::div_beat_t  out_data_o
);
  import rthsv_pkg::*;

  logic      valid_q [DIV_STAGES];
  div_beat_t data_q  [DIV_STAGES];
  logic      ready   [DIV_STAGES+1];
  logic      st_valid[DIV_STAGES];
  div_beat_t st_data [DIV_STAGES];

  assign ready[DIV_STAGES] = out_ready_i;
  assign in_ready_o        = ready[0];
  assign out_valid_o       = valid_q[DIV_STAGES-1];
  assign out_data_o        = data_q[DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_beat_t step_d;

    if (s == 0) begin : g_head
      assign st_valid[s] = in_valid_i;
      assign st_data[s]  = in_data_i;
    end else begin : g_body
      assign st_valid[s] = valid_q[s-1];
      assign st_data[s]  = data_q[s-1];
    end

    assign ready[s] = !valid_q[s] || ready[s+1];

    // the last stage may have fewer than STEPS bits left
    always_comb begin
      step_d = st_data[s];
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < QW) begin
          step_d.hue = div_step(step_d.hue);
          step_d.sat = div_step(step_d.sat);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ready[s]) begin
        valid_q[s] <= st_valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (st_valid[s] && ready[s]) begin
        data_q[s] <= step_d;
      end
    end
  end

endmodule

// ===== rtl/rthsv_back.sv =====
`timescale 1ns / 1ps
// Back end: sign and wrap of the hue, field masking, output register.
module rthsv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rthsv_pkg::div_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rthsv_pkg::hsv_t       out_data_o
);
  import rthsv_pkg::*;

  logic          valid_q;
  hsv_t          data_d, data_q;
  logic [QW-1:0] quo, hue_full;

  assign in_ready_o = !valid_q || out_ready_i;

  // a negative quotient that truncated to zero is not wrapped
  always_comb begin
    quo      = in_data_i.hue.work;
    hue_full = (in_data_i.neg && quo != '0) ? HUE_TURN - quo : quo;
    data_d.hue        = HUE_W'(hue_full);
    data_d.saturation = SAT_W'(in_data_i.sat.work);
    data_d.value      = in_data_i.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
`timescale 1ns / 1ps
// RGB to HSV pixel converter.
//
// pix_i takes one 8-bit red/green/blue pixel per beat; hsv_o gives one
// beat per pixel, in order: hue in degrees times 2^FRAC_BITS, saturation
// on a 0..255 scale times 2^FRAC_BITS, and value, the largest component.
// Both channels move a beat when valid and ready are high at a clock edge.
//
// Throughput: one pixel per clock while hsv_o accepts. From accept to
// output valid a pixel passes two front stages for extremes and
// numerators, DIV_STAGES divider stages that each retire up to four
// quotient bits of both divisions, and the output register.
//
// Every stage has its own valid bit and takes a beat when it is empty or
// its successor moves, so bubbles close up and a stalled hsv_o keeps
// filling the pipe until every stage holds a pixel. Nothing is dropped or
// repeated under backpressure. Reset clears all valid bits; no output
// appears until a pixel has gone through.
module rgb_to_hsv_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  rthsv_rgb_if.sink   pix_i,
  rthsv_hsv_if.source hsv_o
);
  import rthsv_pkg::*;

  logic      fr_valid, fr_ready;
  div_beat_t fr_data;
  logic      dv_valid, dv_ready;
  div_beat_t dv_data;
  hsv_t      out_data;

  rthsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  rthsv_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_data_o  (dv_data)
  );

  rthsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_data_i   (dv_data),
    .out_valid_o (hsv_o.valid),
    .out_ready_i (hsv_o.ready),
    .out_data_o  (out_data)
  );

  assign hsv_o.hue        = out_data.hue;
  assign hsv_o.saturation = out_data.saturation;
  assign hsv_o.value      = out_data.value;

endmodule

// ===== rtl/rthsv_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks on the HSV output stream, bound to the top level.
module rthsv_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        hsv_valid_i,
  input logic                        hsv_ready_i,
  input logic [rthsv_pkg::HUE_W-1:0] hue_i,
  input logic [rthsv_pkg::SAT_W-1:0] saturation_i,
  input logic [rthsv_pkg::VAL_W-1:0] value_i
);
  import rthsv_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && !hsv_ready_i |=> hsv_valid_i)
    else $error("hsv beat withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && !hsv_ready_i |=>
      $stable(hue_i) && $stable(saturation_i) && $stable(value_i))
    else $error("hsv payload changed while stalled");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && value_i == '0 |-> hue_i == '0 && saturation_i == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !hsv_valid_i)
    else $error("output valid right after reset");

endmodule

bind rgb_to_hsv_pixel rthsv_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .hsv_valid_i  (hsv_o.valid),
  .hsv_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .value_i      (hsv_o.value)
);
